// File: rtl/swar_pkg.sv
// shared constants and types for the sliding window altitude regression
package swar_pkg;
    localparam int WINDOW_DEPTH_DEF = 32;
    localparam int MS_PER_S = 1000;
    localparam int SAT_MAX = 8388607;
    localparam int DIV_W = 128;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WRITE,
        ST_WALK,
        ST_PREP,
        ST_DEN,
        ST_NUM,
        ST_DIV_MEAN,
        ST_DIV_MSPD,
        ST_DIV_FSPD,
        ST_DIV_FALT,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic start;
    } t_div_ctl;
endpackage

// File: rtl/sliding_window_altitude_regression.sv
// top level: ring window of altitude samples with mean, speed and line fit
// Usage: one request on the input channel (i_valid, o_stall, i_altitude,
// i_interval_ms) carries an altitude sample and the ms since the previous one.
// Each accepted request yields exactly one result on the output channel
// (o_valid, i_stall, o_mean_altitude, o_mean_speed, o_fit_altitude,
// o_fit_speed, o_window_full). The sample is written into a one-port window
// memory, then the window is walked one entry per cycle accumulating the fit
// sums, after which the wide numerators and denominators are formed from 32x32
// partial products. Four divisions then share one 128-bit restoring divider at
// one bit per cycle; a degenerate fit skips one division. One request is in
// flight at a time; the next one is taken at the earliest in the cycle after
// the result is handed over. o_stall is high from acceptance until the result
// has been handed over. The result sits in output registers while i_stall is
// high; nothing is lost.
// Synchronous active-low reset empties the window (fill count and write
// pointer zero, oldest sample zero); memory contents need no clearing.
module sliding_window_altitude_regression #(
    parameter int WINDOW_DEPTH = swar_pkg::WINDOW_DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic signed [23:0]       i_altitude,
    input  logic [15:0]              i_interval_ms,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic signed [23:0]       o_mean_altitude,
    output logic signed [23:0]       o_mean_speed,
    output logic signed [23:0]       o_fit_altitude,
    output logic signed [23:0]       o_fit_speed,
    output logic                     o_window_full
);
    import swar_pkg::*;

    localparam int AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CW = $clog2(WINDOW_DEPTH + 2);

    logic [39:0] mem [WINDOW_DEPTH];
    logic [39:0] r_rd;

    t_state r_state, n_state;
    logic [AW-1:0] r_wp, r_idx;
    logic [CW-1:0] r_fill, r_i;
    logic signed [23:0] r_oldest, r_in_alt;
    logic [15:0] r_in_ms;
    logic r_rd_v;

    logic signed [33:0] r_sum, r_sy;
    logic [23:0] r_itv, r_x;
    logic [33:0] r_sx;
    logic [56:0] r_sxx;
    logic signed [57:0] r_sxy;

    logic [127:0] r_dd, r_pmag, r_a, r_b;
    logic r_pneg, r_num_neg;
    logic [127:0] r_num, r_den;
    logic signed [23:0] r_mean, r_mspd, r_falt, r_fspd;
    logic r_full;

    t_div_ctl w_ctl;
    logic w_done;
    logic [127:0] w_quo;

    swar_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(w_ctl),
        .i_num(r_num), .i_den(r_den), .o_done(w_done), .o_quo(w_quo)
    );

    function automatic logic [127:0] f_abs(input logic signed [127:0] v);
        f_abs = v[127] ? 128'(-v) : v;
    endfunction

    function automatic logic signed [23:0] f_sat(input logic neg, input logic [127:0] q);
        logic [127:0] lim;
        lim = neg ? 128'(SAT_MAX + 1) : 128'(SAT_MAX);
        if (q > lim) f_sat = neg ? 24'sh800000 : 24'sh7fffff;
        else f_sat = neg ? 24'(-q[23:0]) : q[23:0];
    endfunction

    // 64x64 product over 4 partial products is done one per cycle in ST_DEN
    logic [127:0] r_acc;
    logic [63:0]  r_ma, r_mb;
    logic [1:0]   r_pp;
    logic [63:0]  w_pp;
    always_comb begin
        unique case (r_pp)
            2'd0: w_pp = r_ma[31:0] * r_mb[31:0];
            2'd1: w_pp = r_ma[31:0] * r_mb[63:32];
            2'd2: w_pp = r_ma[63:32] * r_mb[31:0];
            default: w_pp = r_ma[63:32] * r_mb[63:32];
        endcase
    end
    logic [127:0] w_pp_sh;
    always_comb begin
        unique case (r_pp)
            2'd0: w_pp_sh = {64'd0, w_pp};
            2'd1, 2'd2: w_pp_sh = {32'd0, w_pp, 32'd0};
            default: w_pp_sh = {w_pp, 64'd0};
        endcase
    end

    logic [7:0] r_mop;   // multiply sequence index
    logic r_mbusy;
    logic [CW-1:0] w_n;
    logic [33:0] w_nx;
    assign w_n = r_fill + CW'(1);
    // n*x - sx, never negative
    assign w_nx = 34'(w_n) * 34'(r_x) - r_sx;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:     if (i_valid) n_state = ST_WRITE;
            ST_WRITE:    n_state = ST_WALK;
            ST_WALK:     if (r_rd_v && r_i == r_fill) n_state = ST_PREP;
            ST_PREP:     n_state = ST_DEN;
            ST_DEN:      if (!r_mbusy && r_mop == 8'd8) n_state = ST_NUM;
            ST_NUM:      n_state = ST_DIV_MEAN;
            ST_DIV_MEAN: if (w_done) n_state = ST_DIV_MSPD;
            ST_DIV_MSPD: if (w_done) n_state = ST_DIV_FSPD;
            ST_DIV_FSPD: if (w_done || r_dd == '0) n_state = ST_DIV_FALT;
            ST_DIV_FALT: if (w_done) n_state = ST_DONE;
            ST_DONE:     if (!i_stall) n_state = ST_IDLE;
            default:     n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_stall = (r_state != ST_IDLE);
        o_valid = (r_state == ST_DONE);
    end

    logic r_dstart;
    assign w_ctl.start = r_dstart;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_wp <= '0;
            r_fill <= '0;
            r_oldest <= '0;
            r_dstart <= 1'b0;
            r_mbusy <= 1'b0;
        end else begin
            r_state <= n_state;
            r_dstart <= 1'b0;
            unique case (r_state)
                ST_IDLE: if (i_valid) begin
                    r_in_alt <= i_altitude;
                    r_in_ms  <= i_interval_ms;
                end
                ST_WRITE: begin
                    if (r_fill == CW'(WINDOW_DEPTH)) r_oldest <= signed'(r_rd[39:16]);
                    r_wp <= (r_wp == AW'(WINDOW_DEPTH - 1)) ? '0 : r_wp + AW'(1);
                    if (r_fill != CW'(WINDOW_DEPTH)) r_fill <= r_fill + CW'(1);
                    r_idx <= (r_fill == CW'(WINDOW_DEPTH))
                           ? ((r_wp == AW'(WINDOW_DEPTH - 1)) ? '0 : r_wp + AW'(1)) : '0;
                    r_i <= '0;
                    r_rd_v <= 1'b0;
                    r_itv <= '0; r_x <= '0; r_sx <= '0; r_sxx <= '0; r_sxy <= '0;
                end
                ST_WALK: begin
                    if (r_i == '0 && !r_rd_v) begin
                        r_sum <= 34'(r_oldest);
                        r_sy  <= 34'(r_oldest);
                    end
                    if (r_i != r_fill) begin
                        r_idx <= (r_idx == AW'(WINDOW_DEPTH - 1)) ? '0 : r_idx + AW'(1);
                        r_i <= r_i + CW'(1);
                    end
                    r_rd_v <= (r_i != r_fill);
                    if (r_rd_v) begin
                        r_sum <= r_sum + 34'(signed'(r_rd[39:16]));
                        r_itv <= r_itv + 24'(r_rd[15:0]);
                        if (r_rd[15:0] != 16'd0) begin
                            r_x   <= r_x + 24'(r_rd[15:0]);
                            r_sx  <= r_sx + 34'(r_x + 24'(r_rd[15:0]));
                            r_sxx <= r_sxx + 57'((r_x + 24'(r_rd[15:0])) *
                                                  (r_x + 24'(r_rd[15:0])));
                            r_sy  <= r_sy + 34'(signed'(r_rd[39:16]));
                            r_sxy <= r_sxy + 58'($signed({1'b0, r_x + 24'(r_rd[15:0])}) *
                                                  signed'(r_rd[39:16]));
                        end
                    end
                end
                ST_PREP: begin
                    r_full <= (r_fill == CW'(WINDOW_DEPTH));
                    r_mop <= '0;
                    r_mbusy <= 1'b0;
                end
                ST_DEN: begin
                    // sequence of wide products through the shared 32x32 multiplier
                    if (!r_mbusy) begin
                        r_mbusy <= (r_mop != 8'd8);
                        r_pp <= '0;
                        r_acc <= '0;
                        unique case (r_mop)
                            8'd0: begin r_ma <= 64'(r_sxx); r_mb <= 64'(w_n); end
                            8'd1: begin r_ma <= 64'(r_sx); r_mb <= 64'(r_sx); end
                            8'd2: begin r_ma <= 64'(f_abs(128'(r_sxy))); r_mb <= 64'(w_n); end
                            8'd3: begin r_ma <= 64'(f_abs(128'(r_sy))); r_mb <= 64'(r_sx); end
                            8'd4: begin r_ma <= 64'(w_nx); r_mb <= r_pmag[63:0]; end
                            8'd5: begin r_ma <= 64'(w_nx); r_mb <= r_pmag[127:64]; end
                            8'd6: begin r_ma <= r_dd[63:0]; r_mb <= 64'(f_abs(128'(r_sy))); end
                            8'd7: begin r_ma <= r_dd[127:64]; r_mb <= 64'(f_abs(128'(r_sy))); end
                            default: ;
                        endcase
                    end else begin
                        r_acc <= r_acc + w_pp_sh;
                        r_pp <= r_pp + 2'd1;
                        if (r_pp == 2'd3) begin
                            r_mbusy <= 1'b0;
                            r_mop <= r_mop + 8'd1;
                            unique case (r_mop)
                                8'd0: r_dd <= r_acc + w_pp_sh;
                                8'd1: r_dd <= r_dd - (r_acc + w_pp_sh);
                                8'd2: r_a <= r_acc + w_pp_sh;
                                8'd3: begin
                                    // p = n*sxy - sy*sx with signs
                                    if (r_sxy[57] == !r_sy[33] || r_sx == '0) begin
                                        r_pneg <= r_sxy[57];
                                        r_pmag <= r_a + ((r_sx == '0) ? '0 : r_acc + w_pp_sh);
                                        if (r_sx == '0 && r_a == '0) r_pneg <= 1'b0;
                                    end else if (r_a >= r_acc + w_pp_sh) begin
                                        r_pneg <= r_sxy[57];
                                        r_pmag <= r_a - (r_acc + w_pp_sh);
                                    end else begin
                                        r_pneg <= !r_sy[33];
                                        r_pmag <= (r_acc + w_pp_sh) - r_a;
                                    end
                                end
                                8'd4: r_a <= r_acc + w_pp_sh;
                                8'd5: r_a <= r_a + {r_acc[63:0] + w_pp_sh[63:0], 64'd0};
                                8'd6: r_b <= r_acc + w_pp_sh;
                                default: r_b <= r_b + {r_acc[63:0] + w_pp_sh[63:0], 64'd0};
                            endcase
                        end
                    end
                end
                ST_NUM: begin
                    r_num_neg <= r_sum[33];
                    r_num <= f_abs(128'(r_sum));
                    r_den <= 128'(w_n);
                    r_dstart <= 1'b1;
                end
                ST_DIV_MEAN: if (w_done) begin
                    r_mean <= f_sat(r_num_neg, w_quo);
                    r_num_neg <= (signed'(r_rd[39:16]) - r_oldest) < 0;
                    r_num <= f_abs(128'((35'(signed'(r_rd[39:16])) - 35'(r_oldest)) *
                                        35'sd1000));
                    r_den <= (r_itv == '0) ? 128'd1 : 128'(r_itv);
                    r_dstart <= 1'b1;
                end
                ST_DIV_MSPD: if (w_done) begin
                    r_mspd <= (r_itv == '0) ? '0 : f_sat(r_num_neg, w_quo);
                    r_num_neg <= r_pneg;
                    r_num <= r_pmag * 128'd1000;
                    r_den <= (r_dd == '0) ? 128'd1 : r_dd;
                    r_dstart <= (r_dd != '0);
                end
                ST_DIV_FSPD: if (w_done || r_dd == '0) begin
                    r_fspd <= (r_dd == '0) ? '0 : f_sat(r_num_neg, w_quo);
                    if (r_dd == '0) begin
                        r_num_neg <= r_sy[33];
                        r_num <= f_abs(128'(r_sy));
                        r_den <= 128'(w_n);
                    end else if (r_pneg == r_sy[33]) begin
                        r_num_neg <= r_pneg;
                        r_num <= r_a + r_b;
                        r_den <= r_dd * 128'(w_n);
                    end else if (r_a >= r_b) begin
                        r_num_neg <= r_pneg;
                        r_num <= r_a - r_b;
                        r_den <= r_dd * 128'(w_n);
                    end else begin
                        r_num_neg <= r_sy[33];
                        r_num <= r_b - r_a;
                        r_den <= r_dd * 128'(w_n);
                    end
                    r_dstart <= 1'b1;
                end
                ST_DIV_FALT: if (w_done) r_falt <= f_sat(r_num_neg, w_quo);
                default: ;
            endcase
        end
    end

    // window memory: read-modify-write, one port
    logic [AW-1:0] w_raddr;
    always_comb begin
        priority if (r_state == ST_IDLE) w_raddr = r_wp;
        else if (r_state == ST_WALK) w_raddr = r_idx;
        else w_raddr = (r_wp == '0) ? AW'(WINDOW_DEPTH - 1) : r_wp - AW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_WRITE) mem[r_wp] <= {r_in_alt, r_in_ms};
        if (r_state == ST_IDLE || r_state == ST_WALK || r_state == ST_PREP)
            r_rd <= mem[w_raddr];
    end

    assign o_mean_altitude = r_mean;
    assign o_mean_speed    = r_mspd;
    assign o_fit_altitude  = r_falt;
    assign o_fit_speed     = r_fspd;
    assign o_window_full   = r_full;
endmodule

// File: rtl/swar_div.sv
// shared radix-2 unsigned divider, one quotient bit per cycle
module swar_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  swar_pkg::t_div_ctl        i_ctl,
    input  logic [swar_pkg::DIV_W-1:0] i_num,
    input  logic [swar_pkg::DIV_W-1:0] i_den,
    output logic                      o_done,
    output logic [swar_pkg::DIV_W-1:0] o_quo
);
    import swar_pkg::*;

    logic [DIV_W-1:0] r_num, r_den, r_quo;
    logic [DIV_W:0]   r_rem;
    logic [7:0]       r_cnt;
    logic             r_busy, r_done;
    logic [DIV_W:0]   w_sh;

    assign w_sh = {r_rem[DIV_W-1:0], r_num[DIV_W-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 8'(DIV_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 8'd1;
                if (r_cnt == 8'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[DIV_W-2:0], 1'b0};
            if (w_sh >= {1'b0, r_den}) begin
                r_rem <= w_sh - {1'b0, r_den};
                r_quo <= {r_quo[DIV_W-2:0], 1'b1};
            end else begin
                r_rem <= w_sh;
                r_quo <= {r_quo[DIV_W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
endmodule
